FILE: design/sbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the sorted table binary search unit.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int COUNT_W         = 11;
	localparam int INDEX_W         = 10;
	localparam int VALUE_W         = 32;
	localparam int POS_W           = 10;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic                      opcode;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [VALUE_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic mem_wr;
		logic rd_en;
		logic narrow;
		logic res_load;
		logic res_found;
	} sbs_cmd_t;

	typedef struct packed {
		logic wr_ok;
		logic empty;
		logic key_eq;
	} sbs_status_t;

endpackage
`default_nettype wire

FILE: design/sbs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_ctrl
// Controller: accepts transactions, sequences the probes, owns result valid.
// ----------------------------------------------------------------------------
module sbs_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire                       in_opcode,
	output logic                      out_valid,
	input  wire                       out_ready,
	input  wire sbs_pkg::sbs_status_t status,
	output sbs_pkg::sbs_cmd_t         cmd
);
	import sbs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_CMP   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   in_acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_opcode == OP_SEARCH) begin
						cmd.load = 1'b1;
						state_d  = ST_PROBE;
					end else begin
						cmd.mem_wr = status.wr_ok;
					end
				end
			end
			ST_PROBE: begin
				if (status.empty) begin
					if (slot_free) begin
						cmd.res_load = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CMP;
				end
			end
			ST_CMP: begin
				if (status.key_eq) begin
					if (slot_free) begin
						cmd.res_load  = 1'b1;
						cmd.res_found = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.narrow = 1'b1;
					state_d    = ST_PROBE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/sbs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_dp
// Datapath: table memory, count register, search bounds, compare, result.
// ----------------------------------------------------------------------------
module sbs_dp #(
	parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire [sbs_pkg::COUNT_W-1:0]         cfg_wr_data,
	input  wire sbs_pkg::in_item_t             in_item,
	input  wire sbs_pkg::sbs_cmd_t             cmd,
	output sbs_pkg::sbs_status_t               status,
	output sbs_pkg::out_item_t                 out_item
);
	import sbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
	logic signed [VALUE_W-1:0] rd_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [COUNT_W-1:0]        count_q;
	logic [CW-1:0]             lo_q, hi_q;
	logic [CW-1:0]             cnt_sat;
	logic [CW-1:0]             mid;
	logic [31:0]               idx_ext;
	logic [31:0]               mid_ext;
	logic [AW-1:0]             wr_addr;
	logic                      found_q;
	logic [POS_W-1:0]          position_q;

	assign cnt_sat = (32'(count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);
	assign mid     = lo_q + ((hi_q - lo_q - CW'(1)) >> 1);
	assign idx_ext = 32'(in_item.entry_index);
	assign mid_ext = 32'(mid);
	assign wr_addr = idx_ext[AW-1:0];

	assign status.wr_ok  = (idx_ext < 32'(TABLE_DEPTH));
	assign status.empty  = !(lo_q < hi_q);
	assign status.key_eq = (rd_q == key_q);

	assign out_item.found    = found_q;
	assign out_item.position = position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[wr_addr] <= in_item.item_value;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[mid[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_item.item_value;
			lo_q  <= '0;
			hi_q  <= cnt_sat;
		end else if (cmd.narrow) begin
			if (rd_q > key_q) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + CW'(1);
			end
		end
		if (cmd.res_load) begin
			found_q    <= cmd.res_found;
			position_q <= cmd.res_found ? mid_ext[POS_W-1:0] : '0;
		end
	end

endmodule
`default_nettype wire

FILE: design/sorted_table_binary_search_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Table write and binary search over the leading entries of a sorted table.
// ----------------------------------------------------------------------------
// Write transaction: no result.
// Search: each probe is a memory read, then a compare, on the single read port,
// with at most P = ceil(log2(N+1)) probes.
// One transaction in flight at a time; the next is taken the cycle after the
// result is loaded.
// Reset clears the count register and control; the table is not cleared.
module sorted_table_binary_search_unit #(
	parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_wr_en,
	input  wire [sbs_pkg::COUNT_W-1:0] cfg_wr_data,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire sbs_pkg::in_item_t     in_item,
	output logic                       out_valid,
	input  wire                        out_ready,
	output sbs_pkg::out_item_t         out_item
);
	import sbs_pkg::*;

	sbs_cmd_t    cmd;
	sbs_status_t status;

	sbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_opcode (in_item.opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_item),
		.cmd         (cmd),
		.status      (status),
		.out_item    (out_item)
	);

endmodule
`default_nettype wire

FILE: design/sbs_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_chk
// Port-level checks of the search unit, bound to the top level.
// ----------------------------------------------------------------------------
module sbs_chk (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire sbs_pkg::in_item_t     in_item,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire sbs_pkg::out_item_t    out_item
);
	import sbs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |-> out_item.position == '0)
		else $error("miss with nonzero position");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.opcode == OP_WRITE |=> !$rose(out_valid))
		else $error("write transaction produced a result");

	a_search_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.opcode == OP_SEARCH |=> !$rose(out_valid))
		else $error("search result one cycle after accept");

endmodule

bind sorted_table_binary_search_unit sbs_chk u_sbs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
`default_nettype wire

FILE: tb/sorted_table_binary_search_checker.sv
// ----------------------------------------------------------------------------
// sbs_search_checker
// Watches the configuration port and both channels of the sorted table
// binary search unit. Keeps its own mirror of the table and the entry count,
// works out the answer of every accepted search and compares each result
// transaction, field by field, against the oldest pending answer.
// ----------------------------------------------------------------------------
module sbs_search_checker import sbs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [COUNT_W-1:0]     cfg_wr_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  in_item_t               in_item,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  out_item_t              out_item,
	output int                     mismatch_count,
	output int                     answers_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VALUE_W-1:0] entry_mirror [TABLE_DEPTH_DEF];
	logic [COUNT_W-1:0]        count_mirror;
	out_item_t                 answer_q [$];

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH %s", $realtime, msg);
	endtask

	function automatic out_item_t search_answer(input logic signed [VALUE_W-1:0] key);
		int lo;
		int hi;
		int mid;
		out_item_t ans;
		ans = '0;
		lo = 0;
		hi = (count_mirror > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(count_mirror);
		while (lo < hi) begin
			mid = lo + (hi - 1 - lo) / 2;
			if (entry_mirror[mid] == key) begin
				ans.found = 1'b1;
				ans.position = POS_W'(mid);
				return ans;
			end
			if (entry_mirror[mid] > key)
				hi = mid;
			else
				lo = mid + 1;
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			count_mirror = '0;
			answer_q.delete();
			answers_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("result with no search pending: found %b position %0d",
						out_item.found, out_item.position));
				end else begin
					want = answer_q.pop_front();
					if (out_item.found !== want.found)
						report_mismatch($sformatf("found: got %b, want %b",
							out_item.found, want.found));
					if (out_item.position !== want.position)
						report_mismatch($sformatf("position: got %0d, want %0d",
							out_item.position, want.position));
				end
			end
			if (in_valid && in_ready) begin
				if (in_item.opcode == OP_WRITE)
					entry_mirror[in_item.entry_index] = in_item.item_value;
				else
					answer_q.push_back(search_answer(in_item.item_value));
			end
			if (cfg_wr_en)
				count_mirror = cfg_wr_data;
			answers_pending = answer_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sorted table binary search unit. Lays out table
// prefixes with ascending values (some with duplicates, some shuffled), writes
// the entries along each probe path before the search that reads them, sets
// the entry count between phases, and searches for present, absent and
// extreme keys, with both channels idling at random for the first two thirds.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbs_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int ITEM_TARGET  = 700;
	localparam int DRAIN_CYCLES = 32;
	localparam int STALL_LIMIT  = 2000;

	localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	in_item_t           in_item     = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	out_item_t          out_item;
	int                 mismatch_count;
	int                 answers_pending;

	logic signed [VALUE_W-1:0] table_shadow [TABLE_DEPTH_DEF];
	int fill_mark [TABLE_DEPTH_DEF];
	int fill_epoch     = 1;
	int send_idle_pct  = 28;
	int recv_stall_pct = 71;
	int sent_items     = 0;
	int live_count     = 0;
	int quiet_cycles   = 0;

	sorted_table_binary_search_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

	sbs_search_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_item        (out_item),
		.mismatch_count  (mismatch_count),
		.answers_pending (answers_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("sorted_table_binary_search_unit verification failed");
			$finish;
		end
	end

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_SLOW_SINK: begin
				send_idle_pct = 28;
				recv_stall_pct = 71;
			end
			PACE_SLOW_SOURCE: begin
				send_idle_pct = 71;
				recv_stall_pct = 28;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// hold valid and payload until the transaction is taken
	task automatic send_transaction(input in_item_t t);
		if (sent_items < ITEM_TARGET / 3)
			set_pace(PACE_SLOW_SINK);
		else if (sent_items < 2 * ITEM_TARGET / 3)
			set_pace(PACE_SLOW_SOURCE);
		else
			set_pace(PACE_FULL);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_item <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_entry(input int idx, input logic signed [VALUE_W-1:0] v);
		in_item_t t;
		t.opcode = OP_WRITE;
		t.entry_index = INDEX_W'(idx);
		t.item_value = v;
		table_shadow[idx] = v;
		fill_mark[idx] = fill_epoch;
		sent_items++;
		send_transaction(t);
	endtask

	task automatic search_key(input logic signed [VALUE_W-1:0] key);
		in_item_t t;
		t.opcode = OP_SEARCH;
		t.entry_index = INDEX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1));
		t.item_value = key;
		sent_items++;
		send_transaction(t);
	endtask

	// write every laid-out entry that the search for key will probe
	task automatic ensure_path(input logic signed [VALUE_W-1:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = live_count;
		while (lo < hi) begin
			mid = lo + (hi - 1 - lo) / 2;
			if (fill_mark[mid] != fill_epoch)
				write_entry(mid, table_shadow[mid]);
			if (table_shadow[mid] == key)
				break;
			if (table_shadow[mid] > key)
				hi = mid;
			else
				lo = mid + 1;
		end
	endtask

	// drain pending searches, then let the block settle before the write
	task automatic set_entry_count(input logic [COUNT_W-1:0] cnt);
		@(negedge clk);
		in_valid <= 1'b0;
		while (answers_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cnt;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		live_count = (cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(cnt);
	endtask

	task automatic fill_prefix(input int n);
		longint acc;
		int unsigned span;
		bit shuffled;
		bit dense;
		fill_epoch++;
		span = 32'hFFFF_FFFF / (n + 1);
		shuffled = ($urandom_range(0, 5) == 0);
		dense = ($urandom_range(0, 3) == 0);
		acc = -64'sd2147483648 + longint'($urandom_range(0, span));
		for (int i = 0; i < n; i++) begin
			if (shuffled) begin
				table_shadow[i] = $urandom;
			end else begin
				table_shadow[i] = acc[VALUE_W-1:0];
				if (!(dense && $urandom_range(0, 2) == 0))
					acc += longint'($urandom_range(0, 2 * span));
				if (acc > 64'sd2147483647)
					acc = 64'sd2147483647;
			end
		end
	endtask

	task automatic search_phase(input int n_searches);
		int pick;
		int idx;
		logic signed [VALUE_W-1:0] key;
		for (int s = 0; s < n_searches; s++) begin
			pick = $urandom_range(0, 99);
			idx = (live_count == 0) ? 0 : $urandom_range(0, live_count - 1);
			if (pick >= 92) begin
				write_entry($urandom_range(0, TABLE_DEPTH_DEF - 1), $urandom);
				continue;
			end
			if (live_count == 0 || pick < 15)
				key = $urandom;
			else if (pick < 20)
				key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
			else if (pick < 30)
				key = table_shadow[$urandom_range(0, 1) ? 0 : live_count - 1];
			else if (pick < 50)
				key = table_shadow[idx] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
			else
				key = table_shadow[idx];
			ensure_path(key);
			search_key(key);
		end
	endtask

	initial begin
		logic [COUNT_W-1:0] cnt;
		set_pace(PACE_SLOW_SINK);
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		search_key(32'sd0);
		search_key(KEY_MIN);
		write_entry(0, KEY_MIN);
		write_entry(1, -32'sd1);
		write_entry(2, 32'sd0);
		write_entry(3, 32'sd1);
		write_entry(4, KEY_MAX);
		write_entry(TABLE_DEPTH_DEF - 1, 32'sh5A5A_A5A5);
		set_entry_count(11'd5);
		search_key(KEY_MIN);
		search_key(-32'sd1);
		search_key(32'sd0);
		search_key(32'sd1);
		search_key(KEY_MAX);
		search_key(32'sd2);
		search_key(-32'sd2);
		write_entry(2, -32'sd1);
		search_key(-32'sd1);
		write_entry(0, KEY_MAX);
		search_key(KEY_MIN);
		set_entry_count(11'd1);
		search_key(KEY_MAX);

		for (int phase = 0; sent_items < ITEM_TARGET; phase++) begin
			case (phase)
				0: cnt = 11'd1024;
				1: cnt = 11'd2047;
				2: cnt = 11'd1025;
				default: begin
					case ($urandom_range(0, 5))
						0: cnt = COUNT_W'($urandom_range(0, 3));
						1, 2: cnt = COUNT_W'($urandom_range(4, 20));
						3, 4: cnt = COUNT_W'($urandom_range(21, 120));
						default: cnt = COUNT_W'($urandom_range(121, 300));
					endcase
				end
			endcase
			if (phase == 0 || phase > 2)
				fill_prefix((cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(cnt));
			set_entry_count(cnt);
			search_phase((phase < 3) ? 12 : $urandom_range(10, 30));
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (answers_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("sorted_table_binary_search_unit verification clean");
		else
			$display("sorted_table_binary_search_unit verification failed");
		$finish;
	end

endmodule

FILE: files.f
design/sbs_pkg.sv
design/sbs_ctrl.sv
design/sbs_dp.sv
design/sorted_table_binary_search_unit.sv
design/sbs_chk.sv
tb/sorted_table_binary_search_checker.sv
tb/tb.sv
